### design/ardi_pkg.sv
// Shared constants for the action record dedup/insert core.
package ardi_pkg;

    localparam int TABLE_BYTES_DEF = 1024;

    // item kinds carried on s_tuser
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam int KIND_W    = 2;
    localparam int FILTER_W  = 15;
    localparam int NEXT_W    = 11;
    localparam int RADDR_W   = 10;
    localparam int REC_W     = 10;
    localparam int BYTE_W    = 8;
    localparam int SIZE_W    = 11;

    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 32;

    // decoded LEB128 values never exceed three bytes (21 bits)
    localparam int LEB_W     = 21;
    // width used to resolve pointer targets
    localparam int CMP_W     = 23;

endpackage

### design/ardi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ardi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/action_record_dedup_insert_core.sv
// Action record table: dedup lookup, append, clear and byte read.
// Insert: accept, walk the table (one table byte per cycle through the RAM read port,
//   a hit ends it), encode and size the record, write its bytes, then hand off.
// Clear empties the table; read fetches one table byte. s_tready stays low while an item is in work.
// A finished result waits in the output register while the next item is accepted.
// Reset (aresetn low, synchronous) empties the table and clears control state;
// the byte RAM itself is not cleared.
module action_record_dedup_insert_core
    import ardi_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // type_filter[14:0], next_offset[25:15], read_address[35:26], zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // record_offset[9:0], inserted[10], overflow[11], read_byte[19:12],
    // table_size[30:20], zero pad
    output logic [M_DATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam int FW = $clog2(TABLE_BYTES + 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_WALK     = 4'd1;
    localparam logic [3:0] ST_ENC      = 4'd2;
    localparam logic [3:0] ST_SIZE     = 4'd3;
    localparam logic [3:0] ST_WRITE    = 4'd4;
    localparam logic [3:0] ST_RD_ISSUE = 4'd5;
    localparam logic [3:0] ST_RD_TAKE  = 4'd6;
    localparam logic [3:0] ST_DONE     = 4'd7;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          m_valid_reg, m_valid_next;
    logic [FW-1:0] fetch_pos_reg, fetch_pos_next;
    logic [FW-1:0] cons_pos_reg, cons_pos_next;
    logic          pend_reg, pend_next;
    logic          fld_reg, fld_next;
    logic [1:0]    bidx_reg, bidx_next;
    logic [2:0]    wr_k_reg, wr_k_next;

    // payload
    logic [FILTER_W-1:0] filter_reg, filter_next;
    logic [NEXT_W-1:0]   nxt_reg, nxt_next;
    logic [RADDR_W-1:0]  raddr_reg, raddr_next;
    logic [LEB_W-1:0]    acc_reg, acc_next;
    logic                tf_eq_reg, tf_eq_next;
    logic [FW-1:0]       start_reg, start_next;
    logic [FW-1:0]       nrp_reg, nrp_next;
    logic [1:0]          n1_reg, n1_next;
    logic [1:0]          n2_reg, n2_next;
    logic [LEB_W-1:0]    rel_reg, rel_next;
    logic [REC_W-1:0]    res_rec_reg, res_rec_next;
    logic                res_ins_reg, res_ins_next;
    logic                res_ovf_reg, res_ovf_next;
    logic [BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // RAM port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // walk datapath
    logic             issue;
    logic [LEB_W-1:0] part;
    logic [LEB_W-1:0] sign_mask;
    logic [LEB_W-1:0] acc_or;
    logic [LEB_W-1:0] leb_val;
    logic [CMP_W-1:0] target;
    logic [CMP_W-1:0] resolved;
    logic             hit;

    // append datapath
    logic [1:0]       n1_calc;
    logic [1:0]       n2_calc;
    logic [2:0]       tot;
    logic [FW:0]      end_pos;
    logic             ovf_calc;
    logic [BYTE_W-1:0] enc_byte;
    logic [2:0]       pk;
    logic             addr_ok;
    logic             out_free;

    ardi_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_BYTES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign addr_ok  = ({{(32-RADDR_W){1'b0}}, raddr_reg} < 32'(TABLE_BYTES));

    // LEB128 byte decode: place 7 payload bits, sign-extend at the last byte
    always_comb begin
        case (bidx_reg)
            2'd0: begin
                part      = {14'd0, ram_rdata[6:0]};
                sign_mask = 21'h1FFF80;
            end
            2'd1: begin
                part      = {7'd0, ram_rdata[6:0], 7'd0};
                sign_mask = 21'h1FC000;
            end
            default: begin
                part      = {ram_rdata[6:0], 14'd0};
                sign_mask = 21'h000000;
            end
        endcase
        acc_or   = acc_reg | part;
        leb_val  = ram_rdata[6] ? (acc_or | sign_mask) : acc_or;
        target   = {{(CMP_W-NEXT_W){nxt_reg[NEXT_W-1]}}, nxt_reg};
        resolved = CMP_W'(nrp_reg) + {{(CMP_W-LEB_W){leb_val[LEB_W-1]}}, leb_val};
        hit      = (state_reg == ST_WALK) && pend_reg && !ram_rdata[7] && fld_reg
                   && tf_eq_reg && (resolved == target);
        issue    = (state_reg == ST_WALK) && (fetch_pos_reg < fill_reg) && !hit;
    end

    // encoder sizing
    always_comb begin
        if (filter_reg[14:6] == 9'd0) begin
            n1_calc = 2'd1;
        end else if (filter_reg[14:13] == 2'd0) begin
            n1_calc = 2'd2;
        end else begin
            n1_calc = 2'd3;
        end
        if (rel_reg[20:6] == 15'd0 || rel_reg[20:6] == 15'h7FFF) begin
            n2_calc = 2'd1;
        end else if (rel_reg[20:13] == 8'd0 || rel_reg[20:13] == 8'hFF) begin
            n2_calc = 2'd2;
        end else begin
            n2_calc = 2'd3;
        end
        tot      = {1'b0, n1_reg} + {1'b0, n2_reg};
        end_pos  = {1'b0, fill_reg} + (FW+1)'(tot);
        ovf_calc = (end_pos > (FW+1)'(TABLE_BYTES));
    end

    // byte to write: filter bytes first, then pointer bytes
    always_comb begin
        pk = wr_k_reg - {1'b0, n1_reg};
        if (wr_k_reg < {1'b0, n1_reg}) begin
            case (wr_k_reg)
                3'd0:    enc_byte = {(n1_reg > 2'd1), filter_reg[6:0]};
                3'd1:    enc_byte = {(n1_reg > 2'd2), filter_reg[13:7]};
                default: enc_byte = {7'd0, filter_reg[14]};
            endcase
        end else begin
            case (pk)
                3'd0:    enc_byte = {(n2_reg > 2'd1), rel_reg[6:0]};
                3'd1:    enc_byte = {(n2_reg > 2'd2), rel_reg[13:7]};
                default: enc_byte = {1'b0, rel_reg[20:14]};
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        m_valid_next   = m_valid_reg;
        fetch_pos_next = fetch_pos_reg;
        cons_pos_next  = cons_pos_reg;
        pend_next      = 1'b0;
        fld_next       = fld_reg;
        bidx_next      = bidx_reg;
        wr_k_next      = wr_k_reg;
        filter_next    = filter_reg;
        nxt_next       = nxt_reg;
        raddr_next     = raddr_reg;
        acc_next       = acc_reg;
        tf_eq_next     = tf_eq_reg;
        start_next     = start_reg;
        nrp_next       = nrp_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        rel_next       = rel_reg;
        res_rec_next   = res_rec_reg;
        res_ins_next   = res_ins_reg;
        res_ovf_next   = res_ovf_reg;
        res_byte_next  = res_byte_reg;
        m_data_next    = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = AW'(fill_reg + FW'(wr_k_reg));
        ram_wdata = enc_byte;
        ram_re    = 1'b0;
        ram_raddr = AW'(fetch_pos_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    filter_next    = s_tdata[14:0];
                    nxt_next       = s_tdata[25:15];
                    raddr_next     = s_tdata[35:26];
                    res_rec_next   = '0;
                    res_ins_next   = 1'b0;
                    res_ovf_next   = 1'b0;
                    res_byte_next  = '0;
                    fetch_pos_next = '0;
                    cons_pos_next  = '0;
                    fld_next       = 1'b0;
                    bidx_next      = '0;
                    acc_next       = '0;
                    start_next     = '0;
                    case (s_tuser)
                        KIND_INSERT: state_next = ST_WALK;
                        KIND_CLEAR: begin
                            fill_next  = '0;
                            state_next = ST_DONE;
                        end
                        KIND_READ:   state_next = ST_RD_ISSUE;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end

            ST_WALK: begin
                ram_re = issue;
                if (issue) begin
                    fetch_pos_next = fetch_pos_reg + 1'b1;
                    pend_next      = 1'b1;
                end
                if (pend_reg) begin
                    cons_pos_next = cons_pos_reg + 1'b1;
                    if (ram_rdata[7]) begin
                        acc_next  = acc_or;
                        bidx_next = (bidx_reg == 2'd2) ? bidx_reg : bidx_reg + 1'b1;
                    end else begin
                        acc_next  = '0;
                        bidx_next = '0;
                        if (!fld_reg) begin
                            tf_eq_next = (leb_val == LEB_W'(filter_reg));
                            nrp_next   = cons_pos_reg + 1'b1;
                            fld_next   = 1'b1;
                        end else begin
                            start_next = cons_pos_reg + 1'b1;
                            fld_next   = 1'b0;
                        end
                    end
                end
                if (hit) begin
                    res_rec_next = REC_W'(start_reg);
                    state_next   = ST_DONE;
                end else if (!pend_reg && !issue) begin
                    state_next = ST_ENC;
                end
            end

            ST_ENC: begin
                n1_next = n1_calc;
                if (nxt_reg == {NEXT_W{1'b1}}) begin
                    rel_next = '0;
                end else begin
                    rel_next = {{(LEB_W-NEXT_W){nxt_reg[NEXT_W-1]}}, nxt_reg}
                               - LEB_W'(fill_reg) - LEB_W'(n1_calc);
                end
                state_next = ST_SIZE;
            end

            ST_SIZE: begin
                n2_next    = n2_calc;
                wr_k_next  = '0;
                state_next = ST_WRITE;
            end

            ST_WRITE: begin
                if (ovf_calc) begin
                    res_ovf_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    ram_we    = 1'b1;
                    wr_k_next = wr_k_reg + 1'b1;
                    if (wr_k_reg == tot - 1'b1) begin
                        res_rec_next = REC_W'(fill_reg);
                        res_ins_next = 1'b1;
                        fill_next    = end_pos[FW-1:0];
                        state_next   = ST_DONE;
                    end
                end
            end

            ST_RD_ISSUE: begin
                ram_re     = addr_ok;
                ram_raddr  = AW'(raddr_reg);
                state_next = ST_RD_TAKE;
            end

            ST_RD_TAKE: begin
                res_byte_next = addr_ok ? ram_rdata : '0;
                state_next    = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, SIZE_W'(fill_reg), res_byte_reg,
                                    res_ovf_reg, res_ins_reg, res_rec_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
            fetch_pos_reg <= '0;
            cons_pos_reg  <= '0;
            pend_reg      <= 1'b0;
            fld_reg       <= 1'b0;
            bidx_reg      <= '0;
            wr_k_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
            fetch_pos_reg <= fetch_pos_next;
            cons_pos_reg  <= cons_pos_next;
            pend_reg      <= pend_next;
            fld_reg       <= fld_next;
            bidx_reg      <= bidx_next;
            wr_k_reg      <= wr_k_next;
        end
    end

    always_ff @(posedge aclk) begin
        filter_reg   <= filter_next;
        nxt_reg      <= nxt_next;
        raddr_reg    <= raddr_next;
        acc_reg      <= acc_next;
        tf_eq_reg    <= tf_eq_next;
        start_reg    <= start_next;
        nrp_reg      <= nrp_next;
        n1_reg       <= n1_next;
        n2_reg       <= n2_next;
        rel_reg      <= rel_next;
        res_rec_reg  <= res_rec_next;
        res_ins_reg  <= res_ins_next;
        res_ovf_reg  <= res_ovf_next;
        res_byte_reg <= res_byte_next;
        m_data_reg   <= m_data_next;
    end

    // the table never grows past its capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(TABLE_BYTES))
        else $error("fill level beyond table capacity");

    // appends land at the fill level plus the write index, never beyond TABLE_BYTES
    a_append_only: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (fill_reg + FW'(wr_k_reg)) < FW'(TABLE_BYTES + 1))
        else $error("table write outside append window");

    // decode never runs ahead of the fetch pointer
    a_walk_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (cons_pos_reg <= fetch_pos_reg))
        else $error("walk consumed a byte not yet fetched");

    // a result is never both inserted and overflowed
    a_ins_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[10] && m_data_reg[11]))
        else $error("inserted and overflow both set");

    // fill level only moves on a clear or at the end of an append
    a_fill_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != fill_next) |->
            ((state_reg == ST_IDLE) || (state_reg == ST_WRITE)))
        else $error("fill level changed outside clear or append");

endmodule
